>>> rtl/jog_velocity_ramp_3axis_defines.svh
// Assertion macros shared by the jog velocity ramp RTL.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef JOG_VELOCITY_RAMP_3AXIS_DEFINES_SVH
`define JOG_VELOCITY_RAMP_3AXIS_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define JVR_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define JVR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/jvr_pkg.sv
// Shared types and constants for the three-axis jog velocity ramp.
// Has no dependencies; used by jvr_axis and jog_velocity_ramp_3axis.
`default_nettype none

package jvr_pkg;

    localparam int AXES      = 3;
    localparam int NUM_KEYS  = 6;
    localparam int VEL_W     = 32;
    localparam int RATE_W    = 31;
    localparam int DT_W      = 16;
    localparam int FRAC_W    = 16;

    localparam logic [1:0] REQ_KEY  = 2'd0;
    localparam logic [1:0] REQ_TICK = 2'd1;
    localparam logic [1:0] REQ_STOP = 2'd2;

    localparam logic [2:0] KEY_FWD   = 3'd0;
    localparam logic [2:0] KEY_BACK  = 3'd1;
    localparam logic [2:0] KEY_LEFT  = 3'd2;
    localparam logic [2:0] KEY_RIGHT = 3'd3;
    localparam logic [2:0] KEY_UP    = 3'd4;
    localparam logic [2:0] KEY_DOWN  = 3'd5;

    localparam logic [1:0] CFG_MAX_SPEED  = 2'd0;
    localparam logic [1:0] CFG_ACCEL_RATE = 2'd1;
    localparam logic [1:0] CFG_DECEL_RATE = 2'd2;

    localparam logic [RATE_W-1:0] MAX_SPEED_RST  = 31'd1310720;
    localparam logic [RATE_W-1:0] ACCEL_RATE_RST = 31'd6553600;
    localparam logic [RATE_W-1:0] DECEL_RATE_RST = 31'd6553600;

    // Axis order is x (right/left), y (forward/backward), z (up/down).
    localparam logic [2:0] AXIS_PLUS_KEY  [AXES] = '{KEY_RIGHT, KEY_FWD, KEY_UP};
    localparam logic [2:0] AXIS_MINUS_KEY [AXES] = '{KEY_LEFT, KEY_BACK, KEY_DOWN};

    typedef struct packed {
        logic pos;
        logic neg;
    } t_dir;

    typedef struct packed {
        logic [1:0]      req_type;
        logic [2:0]      key_index;
        logic            key_pressed;
        logic [DT_W-1:0] time_step;
    } t_in_beat;

    typedef struct packed {
        logic signed [VEL_W-1:0] vel_x;
        logic signed [VEL_W-1:0] vel_y;
        logic signed [VEL_W-1:0] vel_z;
        logic                    any_key_held;
    } t_out_beat;

endpackage

`default_nettype wire

>>> rtl/jvr_axis.sv
// Velocity update for one axis: one rate times time step multiply, add, and clamp.
// Depends on jvr_pkg.
`default_nettype none

module jvr_axis (
    input  wire jvr_pkg::t_dir                       i_dir,
    input  wire logic signed [jvr_pkg::VEL_W-1:0]    i_vel,
    input  wire logic [jvr_pkg::DT_W-1:0]            i_dt,
    input  wire logic [jvr_pkg::RATE_W-1:0]          i_max_speed,
    input  wire logic [jvr_pkg::RATE_W-1:0]          i_accel_rate,
    input  wire logic [jvr_pkg::RATE_W-1:0]          i_decel_rate,
    output logic signed [jvr_pkg::VEL_W-1:0]         o_vel
);

    localparam int PROD_W = jvr_pkg::VEL_W + jvr_pkg::DT_W;
    localparam int SUM_W  = jvr_pkg::VEL_W + 2;

    logic                    w_moving;
    logic                    w_plus;
    logic                    w_vel_pos;
    logic                    w_vel_neg;
    logic                    w_reverse;
    logic [jvr_pkg::VEL_W-1:0] w_rate;
    logic [PROD_W-1:0]       w_prod;
    logic [jvr_pkg::VEL_W-1:0] w_step;
    logic signed [SUM_W-1:0] w_vel_ext;
    logic signed [SUM_W-1:0] w_step_ext;
    logic signed [SUM_W-1:0] w_sum_up;
    logic signed [SUM_W-1:0] w_sum_dn;
    logic signed [SUM_W-1:0] w_lim;
    logic signed [SUM_W-1:0] w_neg_lim;
    logic signed [SUM_W-1:0] w_raw;
    logic signed [SUM_W-1:0] w_res;

    assign w_moving  = i_dir.pos ^ i_dir.neg;
    assign w_plus    = i_dir.pos;
    assign w_vel_neg = i_vel[jvr_pkg::VEL_W-1];
    assign w_vel_pos = !w_vel_neg && (i_vel != '0);
    assign w_reverse = (w_plus && w_vel_neg) || (!w_plus && w_vel_pos);

    always_comb begin
        if (!w_moving) begin
            w_rate = {1'b0, i_decel_rate};
        end else if (w_reverse) begin
            w_rate = {i_accel_rate, 1'b0};
        end else begin
            w_rate = {1'b0, i_accel_rate};
        end
    end

    assign w_prod     = PROD_W'(w_rate) * PROD_W'(i_dt);
    assign w_step     = w_prod[PROD_W-1:jvr_pkg::FRAC_W];
    assign w_vel_ext  = SUM_W'(i_vel);
    assign w_step_ext = {2'b00, w_step};
    assign w_sum_up   = w_vel_ext + w_step_ext;
    assign w_sum_dn   = w_vel_ext - w_step_ext;
    assign w_lim      = {3'b000, i_max_speed};
    assign w_neg_lim  = -w_lim;

    always_comb begin
        w_raw = w_plus ? w_sum_up : w_sum_dn;
        if (!w_moving) begin
            if (w_vel_pos) begin
                w_res = (w_sum_dn < 0) ? '0 : w_sum_dn;
            end else if (w_vel_neg) begin
                w_res = (w_sum_up > 0) ? '0 : w_sum_up;
            end else begin
                w_res = '0;
            end
        end else if (w_raw > w_lim) begin
            w_res = w_lim;
        end else if (w_raw < w_neg_lim) begin
            w_res = w_neg_lim;
        end else begin
            w_res = w_raw;
        end
    end

    assign o_vel = w_res[jvr_pkg::VEL_W-1:0];

endmodule

`default_nettype wire

>>> rtl/jog_velocity_ramp_3axis.sv
// Top level of the three-axis jog velocity ramp: handshake, key and velocity state.
// Depends on jvr_pkg, jvr_axis and jog_velocity_ramp_3axis_defines.svh.
//
// Each accepted beat is a key change, a tick with a time step, or a stop, and yields
// exactly one result beat with the three axis velocities and a key-held flag. A beat
// waits in the input register while the output register is full; as it moves on, the
// key state, the three axis multiply-add-clamp paths and the velocity state update
// in one registered pass, and it then sits in the output register until taken. The
// block accepts one beat per clock cycle unless the output stalls. Configuration
// writes take effect at once and should only be made while no beat is in flight.
`default_nettype none

`include "jog_velocity_ramp_3axis_defines.svh"

module jog_velocity_ramp_3axis (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire jvr_pkg::t_in_beat                 i_in,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output jvr_pkg::t_out_beat                     o_out,
    input  wire logic                              i_cfg_we,
    input  wire logic [1:0]                        i_cfg_index,
    input  wire logic [jvr_pkg::RATE_W-1:0]        i_cfg_data
);

    logic                              r_in_valid;
    jvr_pkg::t_in_beat                 r_in;
    logic                              r_out_valid;
    jvr_pkg::t_out_beat                r_out;
    logic [jvr_pkg::NUM_KEYS-1:0]      r_keys;
    logic [jvr_pkg::NUM_KEYS-1:0]      n_keys;
    logic signed [jvr_pkg::VEL_W-1:0]  r_vel [jvr_pkg::AXES];
    logic signed [jvr_pkg::VEL_W-1:0]  n_vel [jvr_pkg::AXES];
    logic signed [jvr_pkg::VEL_W-1:0]  w_ramp [jvr_pkg::AXES];
    logic [jvr_pkg::RATE_W-1:0]        r_max_speed;
    logic [jvr_pkg::RATE_W-1:0]        r_accel_rate;
    logic [jvr_pkg::RATE_W-1:0]        r_decel_rate;
    logic                              w_out_free;
    logic                              w_fire;

    assign w_out_free  = !r_out_valid || i_out_ready;
    assign w_fire      = r_in_valid && w_out_free;
    assign o_in_ready  = !r_in_valid || w_out_free;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    generate
        for (genvar g = 0; g < jvr_pkg::AXES; g++) begin : g_axis
            jvr_pkg::t_dir w_dir;

            assign w_dir.pos = r_keys[jvr_pkg::AXIS_PLUS_KEY[g]];
            assign w_dir.neg = r_keys[jvr_pkg::AXIS_MINUS_KEY[g]];

            jvr_axis u_axis (
                .i_dir        (w_dir),
                .i_vel        (r_vel[g]),
                .i_dt         (r_in.time_step),
                .i_max_speed  (r_max_speed),
                .i_accel_rate (r_accel_rate),
                .i_decel_rate (r_decel_rate),
                .o_vel        (w_ramp[g])
            );
        end
    endgenerate

    always_comb begin
        n_keys = r_keys;
        n_vel  = r_vel;
        unique case (r_in.req_type)
            jvr_pkg::REQ_KEY: begin
                for (int k = 0; k < jvr_pkg::NUM_KEYS; k++) begin
                    if (r_in.key_index == 3'(k)) begin
                        n_keys[k] = r_in.key_pressed;
                    end
                end
            end
            jvr_pkg::REQ_TICK: begin
                n_vel = w_ramp;
            end
            jvr_pkg::REQ_STOP: begin
                n_keys = '0;
                for (int a = 0; a < jvr_pkg::AXES; a++) begin
                    n_vel[a] = '0;
                end
            end
            default: begin
                n_keys = r_keys;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_keys       <= '0;
            for (int a = 0; a < jvr_pkg::AXES; a++) begin
                r_vel[a] <= '0;
            end
            r_max_speed  <= jvr_pkg::MAX_SPEED_RST;
            r_accel_rate <= jvr_pkg::ACCEL_RATE_RST;
            r_decel_rate <= jvr_pkg::DECEL_RATE_RST;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (w_out_free) begin
                r_out_valid <= r_in_valid;
            end
            if (w_fire) begin
                r_keys <= n_keys;
                r_vel  <= n_vel;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    jvr_pkg::CFG_MAX_SPEED:  r_max_speed  <= i_cfg_data;
                    jvr_pkg::CFG_ACCEL_RATE: r_accel_rate <= i_cfg_data;
                    jvr_pkg::CFG_DECEL_RATE: r_decel_rate <= i_cfg_data;
                    default: r_max_speed <= r_max_speed;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in;
        end
        if (w_fire) begin
            r_out.vel_x        <= n_vel[0];
            r_out.vel_y        <= n_vel[1];
            r_out.vel_z        <= n_vel[2];
            r_out.any_key_held <= (n_keys != '0);
        end
    end

    `JVR_ASSERT_NEXT(a_stop_clears, i_clk, i_rst_n,
        w_fire && (r_in.req_type == jvr_pkg::REQ_STOP),
        (r_keys == '0) && (r_vel[0] == '0) && (r_vel[1] == '0) && (r_vel[2] == '0),
        "Stop did not clear keys and velocities.")
    `JVR_ASSERT_NEXT(a_out_matches_state, i_clk, i_rst_n, w_fire,
        (r_out.any_key_held == (r_keys != '0)) && (r_out.vel_x == r_vel[0]) &&
        (r_out.vel_y == r_vel[1]) && (r_out.vel_z == r_vel[2]),
        "Result beat does not match the updated state.")
    `JVR_ASSERT_NEXT(a_state_holds, i_clk, i_rst_n, !w_fire,
        $stable(r_keys) && $stable(r_vel[0]) && $stable(r_vel[1]) && $stable(r_vel[2]),
        "State changed without a beat moving to the output register.")
    `JVR_ASSERT_SAME(a_fire_needs_room, i_clk, i_rst_n, w_fire,
        o_in_ready && (!r_out_valid || i_out_ready),
        "A beat advanced while the output register was full.")

endmodule

`default_nettype wire
